// ===== hdl/imf_pkg.sv =====
// ----------------------------------------------------------------------------
// imf_pkg
// Shared constants and types of the streaming median filter: field widths,
// register map, reset sizes and the default sizing of the core.
// ----------------------------------------------------------------------------
package imf_pkg;

   // Field widths
   localparam int PIXEL_W = 8;
   localparam int SIZE_W  = 11;

   // Default sizing of the core
   localparam int DEF_WINDOW     = 3;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // Depth of the queue between the front and back ends
   localparam int QUEUE_DEPTH = 4;

   // Register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REG_IDX_W  = 1;

   localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [SIZE_W-1:0] RESET_SIZE = 11'd1024;

   // Image size as programmed, raw register contents
   typedef struct packed {
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
   } size_cfg_type;

endpackage

// ===== hdl/image_median_filter_core.sv =====
// ----------------------------------------------------------------------------
// image_median_filter_core
// Streaming WINDOW x WINDOW median filter over raster-order grayscale pixels,
// with image width and height set through a register port.
//
//   Channel   Direction  Handshake                 Payload
//   req_      in         req_valid / req_ready     req_pixel
//   rsp_      out        rsp_valid / rsp_ready     rsp_median, rsp_window_valid
//   csr_      in         csr_psel/penable/pwrite   csr_paddr, csr_pwdata, csr_prdata
//
// One pixel per clock sustained while results are taken; every pixel gives exactly one result.
// A pixel passes the queue, the line-store read stage and one sort pass per
// pipeline stage before its result reaches the output register.
// A stalled result holds the whole back end; the front end keeps taking
// pixels until the QUEUE_DEPTH-entry queue fills.
// Reset clears counters, queue and pipeline valids; sizes return to 1024.
// No clearing pass: unwritten line-store words reach only border results.
// ----------------------------------------------------------------------------
module image_median_filter_core #(
   parameter int WINDOW     = imf_pkg::DEF_WINDOW,
   parameter int MAX_WIDTH  = imf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = imf_pkg::DEF_MAX_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [imf_pkg::PIXEL_W-1:0]      req_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [imf_pkg::PIXEL_W-1:0]      rsp_median,
   output logic                             rsp_window_valid,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [imf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [imf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [imf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   import imf_pkg::*;

   localparam int EW = PIXEL_W + $clog2(MAX_WIDTH) + 1;

   logic [SIZE_W-1:0]    width_ff, width_in, height_ff, height_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 csr_wr;
   size_cfg_type         size_cfg;

   logic                 push_valid, push_ready, pop_valid, pop_ready;
   logic [EW-1:0]        push_data, pop_data;

   // Register port: no wait states
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1 -: REG_IDX_W];

   // Decode the register write
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         case (reg_idx)
            REG_IMAGE_WIDTH:  width_in  = csr_pwdata[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_SIZE;
         height_ff <= RESET_SIZE;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign size_cfg.width  = width_ff;
   assign size_cfg.height = height_ff;

   imf_front #(
      .WINDOW    (WINDOW),
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .size_cfg  (size_cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pixel (req_pixel),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data)
   );

   imf_queue #(
      .WIDTH(EW),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data)
   );

   imf_back #(
      .WINDOW   (WINDOW),
      .MAX_WIDTH(MAX_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (pop_valid),
      .q_ready         (pop_ready),
      .q_data          (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_median      (rsp_median),
      .rsp_window_valid(rsp_window_valid)
   );

endmodule

// ===== hdl/imf_ram.sv =====
// ----------------------------------------------------------------------------
// imf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// Read data updates only when the read enable is high.
// ----------------------------------------------------------------------------
module imf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/imf_front.sv =====
// ----------------------------------------------------------------------------
// imf_front
// Front end: takes pixels, tracks the raster position and tags each pixel
// with its line-store column and whether it completes a full window.
// ----------------------------------------------------------------------------
module imf_front #(
   parameter int WINDOW     = imf_pkg::DEF_WINDOW,
   parameter int MAX_WIDTH  = imf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = imf_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  imf_pkg::size_cfg_type                       size_cfg,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic [imf_pkg::PIXEL_W-1:0]                 req_pixel,
   output logic                                        push_valid,
   input  logic                                        push_ready,
   output logic [imf_pkg::PIXEL_W+$clog2(MAX_WIDTH):0] push_data
);

   import imf_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int CMPW_C = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
   localparam int CMPW_R = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [CMPW_C-1:0] width_eff, col_sum;
   logic [CMPW_R-1:0] height_eff, row_sum;
   logic              last_col, last_row, win_full, take;

   // Clamp the programmed size: zero acts as one, beyond the maximum as the maximum
   always_comb begin
      if (size_cfg.width == '0) begin
         width_eff = CMPW_C'(1);
      end else if (CMPW_C'(size_cfg.width) > CMPW_C'(MAX_WIDTH)) begin
         width_eff = CMPW_C'(MAX_WIDTH);
      end else begin
         width_eff = CMPW_C'(size_cfg.width);
      end
      if (size_cfg.height == '0) begin
         height_eff = CMPW_R'(1);
      end else if (CMPW_R'(size_cfg.height) > CMPW_R'(MAX_HEIGHT)) begin
         height_eff = CMPW_R'(MAX_HEIGHT);
      end else begin
         height_eff = CMPW_R'(size_cfg.height);
      end
   end

   // Work out the wrap points of the raster counters
   assign col_sum  = CMPW_C'(col_ff) + CMPW_C'(1);
   assign row_sum  = CMPW_R'(row_ff) + CMPW_R'(1);
   assign last_col = (col_sum >= width_eff);
   assign last_row = (row_sum >= height_eff);
   assign win_full = (col_ff >= CW'(WINDOW - 1)) && (row_ff >= RW'(WINDOW - 1));
   assign take     = req_valid && push_ready;

   // Advance column and row, wrapping at the end of each row and frame
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (take) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Hand the tagged pixel to the queue
   assign push_valid = req_valid;
   assign req_ready  = push_ready;
   assign push_data  = {req_pixel, col_ff, win_full};

endmodule

// ===== hdl/imf_queue.sv =====
// ----------------------------------------------------------------------------
// imf_queue
// Short first-in first-out queue between the front and back ends, so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module imf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = imf_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != NW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/imf_back.sv =====
// ----------------------------------------------------------------------------
// imf_back
// Back end: reads and ages the line stores, shifts the window and finds the
// median with a pipelined odd-even transposition sort. The whole back end
// moves under one advance enable taken from the output register.
// ----------------------------------------------------------------------------
module imf_back #(
   parameter int WINDOW    = imf_pkg::DEF_WINDOW,
   parameter int MAX_WIDTH = imf_pkg::DEF_MAX_WIDTH
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        q_valid,
   output logic                                        q_ready,
   input  logic [imf_pkg::PIXEL_W+$clog2(MAX_WIDTH):0] q_data,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic [imf_pkg::PIXEL_W-1:0]                 rsp_median,
   output logic                                        rsp_window_valid
);

   import imf_pkg::*;

   localparam int LINES = WINDOW - 1;
   localparam int AREA  = WINDOW * WINDOW;
   localparam int NSTG  = AREA;
   localparam int MID   = AREA / 2;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int LW    = PIXEL_W * LINES;
   localparam int EW    = PIXEL_W + CW + 1;

   logic                adv;
   logic [PIXEL_W-1:0]  q_pixel;
   logic [CW-1:0]       q_addr;
   logic                q_win;

   // Read stage
   logic                s1_valid_ff;
   logic [PIXEL_W-1:0]  s1_pixel_ff;
   logic [CW-1:0]       s1_addr_ff;
   logic                s1_win_ff;
   logic                s1_fwd_ff, s1_fwd_in;
   logic [LW-1:0]       s1_fwd_word_ff;

   logic [LW-1:0]       ls_rdata, ls_old, ls_wdata;
   logic                ls_we;
   logic [PIXEL_W-1:0]  col [0:WINDOW-1];

   logic [PIXEL_W-1:0]  win_ff [0:AREA-1];
   logic [PIXEL_W-1:0]  win_in [0:AREA-1];

   // Sort pipeline
   logic                srt_valid_ff [0:NSTG];
   logic                srt_keep_ff  [0:NSTG];
   logic [PIXEL_W-1:0]  srt_data_ff  [0:NSTG][0:AREA-1];
   logic [PIXEL_W-1:0]  pass_data    [0:NSTG-1][0:AREA-1];

   // Unpack the queue entry
   assign q_pixel = q_data[EW-1 -: PIXEL_W];
   assign q_addr  = q_data[CW:1];
   assign q_win   = q_data[0];

   // Advance whenever the output register is empty or being taken
   assign adv     = !srt_valid_ff[NSTG] || rsp_ready;
   assign q_ready = adv;

   // Line stores: one word per column, lane k holds the row k+1 above
   imf_ram #(
      .WIDTH(LW),
      .DEPTH(MAX_WIDTH)
   ) u_line_store (
      .clock(clock),
      .we   (ls_we),
      .waddr(s1_addr_ff),
      .wdata(ls_wdata),
      .re   (adv),
      .raddr(q_addr),
      .rdata(ls_rdata)
   );

   // Forward the word written on the same edge that the read was issued
   assign s1_fwd_in = s1_valid_ff && (s1_addr_ff == q_addr);
   assign ls_old    = s1_fwd_ff ? s1_fwd_word_ff : ls_rdata;
   assign ls_wdata  = {ls_old[LW-PIXEL_W-1:0], s1_pixel_ff};
   assign ls_we     = adv && s1_valid_ff;

   // Build the new column, oldest row first, and shift it into the window
   always_comb begin
      for (int r = 0; r < LINES; r++) begin
         col[r] = ls_old[PIXEL_W*(LINES-1-r) +: PIXEL_W];
      end
      col[WINDOW-1] = s1_pixel_ff;
      for (int r = 0; r < WINDOW; r++) begin
         for (int k = 0; k < WINDOW - 1; k++) begin
            win_in[r*WINDOW+k] = win_ff[r*WINDOW+k+1];
         end
         win_in[r*WINDOW+WINDOW-1] = col[r];
      end
   end

   // One compare-exchange pass per stage, even and odd pairs in turn
   for (genvar g = 0; g < NSTG; g++) begin : g_pass
      always_comb begin
         for (int i = 0; i < AREA; i++) begin
            pass_data[g][i] = srt_data_ff[g][i];
         end
         for (int i = g % 2; i + 1 < AREA; i += 2) begin
            if (srt_data_ff[g][i] > srt_data_ff[g][i+1]) begin
               pass_data[g][i]   = srt_data_ff[g][i+1];
               pass_data[g][i+1] = srt_data_ff[g][i];
            end
         end
      end
   end

   // Control: valid flags of the read stage and the sort stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         for (int k = 0; k <= NSTG; k++) begin
            srt_valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         s1_valid_ff     <= q_valid;
         srt_valid_ff[0] <= s1_valid_ff;
         for (int k = 0; k < NSTG; k++) begin
            srt_valid_ff[k+1] <= srt_valid_ff[k];
         end
      end
   end

   // Payload: hold on stall, advance otherwise
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pixel_ff    <= q_pixel;
         s1_addr_ff     <= q_addr;
         s1_win_ff      <= q_win;
         s1_fwd_ff      <= s1_fwd_in;
         s1_fwd_word_ff <= ls_wdata;
         if (s1_valid_ff) begin
            for (int i = 0; i < AREA; i++) begin
               win_ff[i] <= win_in[i];
            end
         end
         srt_keep_ff[0] <= s1_win_ff;
         for (int i = 0; i < AREA; i++) begin
            srt_data_ff[0][i] <= win_in[i];
         end
         for (int k = 0; k < NSTG; k++) begin
            srt_keep_ff[k+1] <= srt_keep_ff[k];
            for (int i = 0; i < AREA; i++) begin
               srt_data_ff[k+1][i] <= pass_data[k][i];
            end
         end
      end
   end

   // Drive the result: border positions give zero
   assign rsp_valid        = srt_valid_ff[NSTG];
   assign rsp_window_valid = srt_keep_ff[NSTG];
   assign rsp_median       = srt_keep_ff[NSTG] ? srt_data_ff[NSTG][MID] : '0;

endmodule

// ===== hdl/imf_checker.sv =====
// ----------------------------------------------------------------------------
// imf_checker
// Port-level checks of the median filter core, bound to the top level.
// ----------------------------------------------------------------------------
module imf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [imf_pkg::PIXEL_W-1:0] rsp_median,
   input logic                        rsp_window_valid
);

   // A stalled result transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median)
                                  && $stable(rsp_window_valid))
      else $error("result changed while stalled");

   // Border positions report a zero median
   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_window_valid |-> rsp_median == '0)
      else $error("border result with non-zero median");

   // Reset empties the pipeline and the queue
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // The front end stalls only while a result waits at the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

endmodule

bind image_median_filter_core imf_checker u_imf_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming 3x3 median filter. Pixels are streamed
// in frames at a range of programmed image sizes, including the clamped
// and degenerate ones. A local model of the line stores, window and raster
// counters predicts every result, and each returned median and window flag is
// compared in order. Both channels idle at random, and the result side is held
// off for long stretches so that the core backs up into its input.
// ----------------------------------------------------------------------------
import imf_pkg::*;

typedef struct packed {
   logic [PIXEL_W-1:0] median;
   logic               window_valid;
} filter_result_type;

// Tracks the filter state and holds the medians still owed by the core
class median_tracker;
   localparam int WIN   = DEF_WINDOW;
   localparam int AREA  = WIN * WIN;
   localparam int LINES = WIN - 1;
   localparam int MAX_W = DEF_MAX_WIDTH;
   localparam int MAX_H = DEF_MAX_HEIGHT;
   localparam int REPORT_CAP = 50;

   logic [PIXEL_W-1:0] row_above [LINES][MAX_W];   // [0] is the row just above
   logic [PIXEL_W-1:0] window_px [AREA];
   int unsigned        col_pos;
   int unsigned        row_pos;
   logic [SIZE_W-1:0]  width_reg;
   logic [SIZE_W-1:0]  height_reg;
   filter_result_type  expected_medians [$];
   int unsigned        errors;
   int unsigned        full_windows;
   int unsigned        border_results;

   function new();
      foreach (row_above[r, c]) row_above[r][c] = '0;
      foreach (window_px[i]) window_px[i] = '0;
      col_pos        = 0;
      row_pos        = 0;
      width_reg      = RESET_SIZE;
      height_reg     = RESET_SIZE;
      errors         = 0;
      full_windows   = 0;
      border_results = 0;
   endfunction

   // Zero acts as one, anything above the maximum acts as the maximum
   function int unsigned fit_size(logic [SIZE_W-1:0] v, int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function int unsigned frame_pixels();
      return fit_size(width_reg, MAX_W) * fit_size(height_reg, MAX_H);
   endfunction

   function int unsigned pending();
      return expected_medians.size();
   endfunction

   function logic [SIZE_W-1:0] size_reg(logic [REG_IDX_W-1:0] idx);
      return (idx == REG_IMAGE_WIDTH) ? width_reg : height_reg;
   endfunction

   function void set_size(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      if (idx == REG_IMAGE_WIDTH) width_reg = value[SIZE_W-1:0];
      else if (idx == REG_IMAGE_HEIGHT) height_reg = value[SIZE_W-1:0];
   endfunction

   // Pick the value whose rank covers the middle of the window
   function logic [PIXEL_W-1:0] middle_value();
      int i, j, below, equal;
      for (i = 0; i < AREA; i++) begin
         below = 0;
         equal = 0;
         for (j = 0; j < AREA; j++) begin
            if (window_px[j] < window_px[i]) below++;
            else if (window_px[j] == window_px[i]) equal++;
         end
         if (below <= AREA / 2 && below + equal > AREA / 2) return window_px[i];
      end
      return '0;
   endfunction

   // Advance the model by one accepted pixel and queue the result it owes
   function void take_pixel(logic [PIXEL_W-1:0] px);
      int unsigned        w, h;
      int                 r, k;
      logic [PIXEL_W-1:0] column [WIN];
      filter_result_type  res;
      w = fit_size(width_reg, MAX_W);
      h = fit_size(height_reg, MAX_H);
      // Gather the new column, oldest row first
      for (r = 0; r < LINES; r++) column[r] = row_above[LINES - 1 - r][col_pos];
      column[WIN - 1] = px;
      // Age the line stores at this column
      for (k = LINES - 1; k > 0; k--) row_above[k][col_pos] = row_above[k - 1][col_pos];
      row_above[0][col_pos] = px;
      // Shift the window left and drop the new column in on the right
      for (r = 0; r < WIN; r++) begin
         for (k = 0; k < WIN - 1; k++) window_px[r * WIN + k] = window_px[r * WIN + k + 1];
         window_px[r * WIN + WIN - 1] = column[r];
      end
      res.window_valid = (col_pos >= LINES) && (row_pos >= LINES);
      res.median       = res.window_valid ? middle_value() : '0;
      expected_medians.push_back(res);
      // Step the raster position, wrapping at row and frame ends
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
   endfunction

   function void report(string what, int unsigned want, int unsigned got);
      errors++;
      if (errors <= REPORT_CAP)
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
   endfunction

   // Compare one transaction from the core with the oldest queued result
   function void check_result(logic [PIXEL_W-1:0] median, logic window_valid);
      filter_result_type want;
      if (expected_medians.size() == 0) begin
         errors++;
         if (errors <= REPORT_CAP)
            $display("%0t: unexpected result: expected none, actual median %0d valid %0b",
                     $time, median, window_valid);
         return;
      end
      want = expected_medians.pop_front();
      if (window_valid !== want.window_valid)
         report("window_valid", want.window_valid, window_valid);
      if (median !== want.median) report("median", want.median, median);
      if (want.window_valid) full_windows++;
      else border_results++;
   endfunction
endclass

module testbench;

   typedef enum int {PIX_NOISE, PIX_EXTREME, PIX_BAND} pixel_style_type;
   typedef enum int {DRAIN_ALWAYS, DRAIN_RANDOM, DRAIN_SPARSE} drain_mode_type;

   localparam int SETTLE_CYCLES = DEF_WINDOW * DEF_WINDOW + 2 + 4;
   localparam int LONG_HOLD     = 120;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int RANDOM_PHASES = 6;
   localparam int BIG_PHASE     = 4;
   localparam int TAIL_PIXELS   = 300;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [PIXEL_W-1:0]    req_pixel;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [PIXEL_W-1:0]    rsp_median;
   logic                  rsp_window_valid;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   median_tracker         tracker;
   int unsigned           cycle_count = 0;
   int unsigned           input_stalls = 0;
   int unsigned           pixels_in = 0;
   int unsigned           sizes_set = 0;
   int unsigned           hold_requests = 0;
   int unsigned           burst_left = 0;
   bit                    continuous = 1'b0;
   logic [PIXEL_W-1:0]    band_base = '0;

   image_median_filter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_median       (rsp_median),
      .rsp_window_valid (rsp_window_valid),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #5 clock = ~clock;

   // Count cycles, note input back-pressure and stop a run that hangs
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_valid && !req_ready) input_stalls++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: run did not complete within %0d cycles", $time, LIMIT_CYCLES);
         $display("** image_median_filter_core: FAILED **");
         $finish;
      end
   end

   function automatic logic [PIXEL_W-1:0] pick_pixel(pixel_style_type style);
      logic [PIXEL_W-1:0] v;
      case (style)
         PIX_EXTREME: begin
            case ($urandom_range(0, 3))
               0: v = 8'h00;
               1: v = 8'hFF;
               2: v = 8'h7F;
               default: v = 8'h80;
            endcase
         end
         PIX_BAND: v = band_base + 8'($urandom_range(0, 6));
         default: v = 8'($urandom);
      endcase
      return v;
   endfunction

   // Offer one pixel, hold it until taken, then maybe pause between bursts
   task automatic offer_pixel(input logic [PIXEL_W-1:0] px);
      int gap;
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_pixel(px);
      pixels_in++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = continuous ? 1000000 : $urandom_range(1, 24);
         gap        = continuous ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            req_pixel <= 8'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic stream_pixels(input int unsigned count, input pixel_style_type style);
      for (int unsigned n = 0; n < count; n++) offer_pixel(pick_pixel(style));
      req_valid <= 1'b0;
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      tracker.set_size(idx, value);
   endtask

   // Read back during the access cycle, away from the clock edge
   task automatic read_reg(input logic [REG_IDX_W-1:0] idx);
      logic [CSR_DATA_W-1:0] data;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      data = csr_prdata;
      @(posedge clock);
      if (data[SIZE_W-1:0] !== tracker.size_reg(idx))
         tracker.report("register readback", tracker.size_reg(idx), data[SIZE_W-1:0]);
   endtask

   // Drain the core, then program a new image size and read it back
   task automatic program_size(input int w, input int h);
      logic [CSR_DATA_W-1:0] word;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      word = $urandom;
      word[SIZE_W-1:0] = w[SIZE_W-1:0];
      write_reg(REG_IMAGE_WIDTH, word);
      word = $urandom;
      word[SIZE_W-1:0] = h[SIZE_W-1:0];
      write_reg(REG_IMAGE_HEIGHT, word);
      read_reg(REG_IMAGE_WIDTH);
      read_reg(REG_IMAGE_HEIGHT);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      sizes_set++;
   endtask

   // Result side: check each transaction, stall on a drifting pattern
   initial begin : drain
      drain_mode_type mode;
      int             mode_left;
      int             hold_left;
      int unsigned    holds_served;
      mode         = DRAIN_ALWAYS;
      mode_left    = 0;
      hold_left    = 0;
      holds_served = 0;
      rsp_ready    <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) tracker.check_result(rsp_median, rsp_window_valid);
         if (mode_left == 0) begin
            mode      = drain_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(30, 200);
         end else begin
            mode_left--;
         end
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               DRAIN_ALWAYS: rsp_ready <= 1'b1;
               DRAIN_RANDOM: rsp_ready <= ($urandom_range(0, 1) == 1);
               default:      rsp_ready <= (mode_left % 4 == 0);
            endcase
         end
      end
   end

   // Stimulus: directed frames, random frame sizes, then a tall partial frame
   initial begin : stimulus
      int              i, p, w, h, frames;
      pixel_style_type style;
      tracker     = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_pixel   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sizes after reset
      read_reg(REG_IMAGE_WIDTH);
      read_reg(REG_IMAGE_HEIGHT);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;

      // Smallest full frame: alternating extremes, then distinct shuffled levels
      program_size(3, 3);
      for (i = 0; i < 9; i++) offer_pixel((i % 2 == 0) ? 8'hFF : 8'h00);
      for (i = 0; i < 9; i++) offer_pixel(8'(((i * 4) % 9) * 30 + 5));
      req_valid <= 1'b0;

      // Zero sizes act as a one-pixel frame: every result is a border
      program_size(0, 0);
      offer_pixel(8'hFF);
      offer_pixel(8'h00);
      offer_pixel(8'h80);
      req_valid <= 1'b0;

      // Random frame sizes, mostly small, with one at the widest clamp
      for (p = 0; p < RANDOM_PHASES; p++) begin
         continuous = ($urandom_range(0, 3) == 0);
         burst_left = 0;
         style      = pixel_style_type'($urandom_range(0, 2));
         band_base  = 8'($urandom);
         frames     = $urandom_range(1, 2);
         w          = $urandom_range(3, 20);
         h          = $urandom_range(3, 10);
         if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1) == 1) w = $urandom_range(0, 2);
            else h = $urandom_range(0, 2);
         end
         if (p == BIG_PHASE) begin
            w      = 2047;
            h      = 1;
            frames = 1;
         end
         program_size(w, h);
         // Back the result side up hard a couple of times
         if (p == 1 || p == BIG_PHASE) begin
            continuous = 1'b1;
            hold_requests++;
         end
         stream_pixels(frames * tracker.frame_pixels(), style);
      end

      // Tallest clamp on a narrow image; the frame is left unfinished
      continuous = 1'b0;
      burst_left = 0;
      program_size(3, 2047);
      stream_pixels(TAIL_PIXELS, PIX_NOISE);

      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d pixels over %0d programmed sizes: %0d full windows, %0d borders",
               pixels_in, sizes_set, tracker.full_windows, tracker.border_results);
      $display("Input held back for %0d cycles by stalled results", input_stalls);
      if (tracker.errors == 0) begin
         $display("** image_median_filter_core: PASSED **");
      end else begin
         $display("%0d mismatches found", tracker.errors);
         $display("** image_median_filter_core: FAILED **");
      end
      $finish;
   end

endmodule
